/* rtl/core/icl_pkg.sv */
// icl_pkg: shared types, constants and helpers for the instruction cache
// used by the cache top level and its memories
`default_nettype none
package icl_pkg;
    localparam int SET_COUNT      = 8;
    localparam int WAY_COUNT      = 4;
    localparam int LINE_WORDS     = 8;
    localparam int PREFETCH_SLOTS = 4;
    localparam int MEM_ROWS       = 4096;

    localparam int SET_W   = $clog2(SET_COUNT);
    localparam int WAY_W   = $clog2(WAY_COUNT);
    localparam int WORD_W  = $clog2(LINE_WORDS);
    localparam int SLOT_W  = $clog2(PREFETCH_SLOTS);
    localparam int ROW_W   = $clog2(MEM_ROWS);
    localparam int LINE_W  = 58;
    localparam int TAG_W   = LINE_W - SET_W;
    localparam int LRAM_AW = SET_W + WAY_W + WORD_W;
    localparam int LAT_W   = 8;
    localparam int CNT_W   = 32;

    // request commands
    localparam logic CMD_FETCH = 1'b0;
    localparam logic CMD_LOAD  = 1'b1;

    typedef logic [WAY_COUNT-1:0][WAY_W-1:0] lru_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_WORD,
        ST_SLOT,
        ST_DEMAND,
        ST_QUEUE,
        ST_FILL,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic             we;
        logic [ROW_W-1:0] waddr;
        logic [63:0]      wdata;
        logic             re;
        logic [ROW_W-1:0] raddr;
    } bmem_req_t;

    typedef struct packed {
        logic               we;
        logic [LRAM_AW-1:0] waddr;
        logic [63:0]        wdata;
        logic               re;
        logic [LRAM_AW-1:0] raddr;
    } lram_req_t;

    // move a way to the front of the order, shifting the ways ahead of it back
    function automatic lru_t make_mru(lru_t o, logic [WAY_W-1:0] way);
        lru_t r;
        int   pos;
        pos = 0;
        for (int i = WAY_COUNT - 1; i >= 0; i--) begin
            if (o[i] == way) begin
                pos = i;
            end
        end
        r[0] = way;
        for (int i = 1; i < WAY_COUNT; i++) begin
            r[i] = (i <= pos) ? o[i-1] : o[i];
        end
        return r;
    endfunction
endpackage
`default_nettype wire

/* rtl/core/icl_backing_mem.sv */
// icl_backing_mem: backing word store, one write and one registered read port
// depends on icl_pkg
`default_nettype none
module icl_backing_mem
    import icl_pkg::*;
(
    input  wire logic      aclk,
    input  wire bmem_req_t req,
    output logic [63:0]    rdata
);
    logic [63:0] mem [MEM_ROWS];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rdata <= mem[req.raddr];
        end
    end
endmodule
`default_nettype wire

/* rtl/core/icl_line_ram.sv */
// icl_line_ram: cached line words indexed by set, way and word
// depends on icl_pkg
`default_nettype none
module icl_line_ram
    import icl_pkg::*;
(
    input  wire logic      aclk,
    input  wire lram_req_t req,
    output logic [63:0]    rdata
);
    logic [63:0] mem [SET_COUNT*WAY_COUNT*LINE_WORDS];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rdata <= mem[req.raddr];
        end
    end
endmodule
`default_nettype wire

/* rtl/core/icache_lru_next_line_prefetch.sv */
// icache_lru_next_line_prefetch: 8-set 4-way instruction cache top level
// depends on icl_pkg, icl_backing_mem, icl_line_ram
//
// After reset the block sweeps the 4096-row backing store to zero, one row a
// cycle, and takes no request meanwhile; latency writes on cfg_wr_en are
// taken at any time. Requests are handled one at a time by a sequencer. A
// load request passes an accept step and a result hand-off step, and its
// result is then offered from the result register. A fetch request with four
// prefetch slots passes an accept step, a lookup, a word read, one walk step
// per slot plus the walk end, a demand step and a result hand-off; each fired
// slot adds one queued line and a closing step, a demand fill or a hit adds
// two queued lines and a closing step, a fresh miss that takes over no pending
// prefetch adds one queued line and a closing step, and each line fill streams
// eight words through the single read port of the backing store into the line
// word memory. The hand-off waits while the result register is still held by
// m_ready low. The result register lets the next request be taken while a
// finished result still waits on m_ready.
`default_nettype none
module icache_lru_next_line_prefetch
    import icl_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_cmd,
    input  wire logic [63:0] s_pc,
    input  wire logic        s_flush,
    input  wire logic [11:0] s_mem_index,
    input  wire logic [63:0] s_mem_word,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_instr_word,
    output logic             m_ready_res,
    output logic [31:0]      m_miss_total,
    output logic [31:0]      m_stall_total
);
    // sequencer and configuration
    state_t             state_reg, state_next;
    logic [ROW_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [LAT_W-1:0]   lat_reg, lat_next;

    // tag store, valid bits and lru order per set
    logic [TAG_W-1:0]   tag_reg [SET_COUNT][WAY_COUNT];
    logic [TAG_W-1:0]   tag_next [SET_COUNT][WAY_COUNT];
    logic [SET_COUNT-1:0][WAY_COUNT-1:0] valid_reg, valid_next;
    lru_t               lru_reg [SET_COUNT];
    lru_t               lru_next [SET_COUNT];

    // prefetch slots and demand miss
    logic [PREFETCH_SLOTS-1:0] pf_pend_reg, pf_pend_next;
    logic [LINE_W-1:0]  pf_line_reg [PREFETCH_SLOTS];
    logic [LINE_W-1:0]  pf_line_next [PREFETCH_SLOTS];
    logic [LAT_W-1:0]   pf_cd_reg [PREFETCH_SLOTS];
    logic [LAT_W-1:0]   pf_cd_next [PREFETCH_SLOTS];
    logic               d_pend_reg, d_pend_next;
    logic [LINE_W-1:0]  d_line_reg, d_line_next;
    logic [LAT_W-1:0]   d_cd_reg, d_cd_next;
    logic [CNT_W-1:0]   miss_reg, miss_next;
    logic [CNT_W-1:0]   stall_reg, stall_next;

    // current request
    logic [LINE_W-1:0]  cur_line_reg, cur_line_next;
    logic [WORD_W-1:0]  cur_word_reg, cur_word_next;
    logic               cur_flush_reg, cur_flush_next;
    logic [63:0]        res_word_reg, res_word_next;
    logic               res_rdy_reg, res_rdy_next;

    // slot walk, queue steps and line fill
    logic [SLOT_W:0]    slot_reg, slot_next;
    logic [LINE_W-1:0]  q_base_reg, q_base_next;
    logic [1:0]         q_left_reg, q_left_next;
    state_t             q_ret_reg, q_ret_next;
    logic [LINE_W-1:0]  fill_line_reg, fill_line_next;
    state_t             fill_ret_reg, fill_ret_next;
    logic [WORD_W:0]    fill_cnt_reg, fill_cnt_next;

    // result register
    logic               m_valid_reg, m_valid_next;
    logic [63:0]        m_word_reg, m_word_next;
    logic               m_rdy_reg, m_rdy_next;
    logic [CNT_W-1:0]   m_miss_reg, m_miss_next;
    logic [CNT_W-1:0]   m_stall_reg, m_stall_next;

    bmem_req_t   bm_req;
    logic [63:0] bm_rdata;
    lram_req_t   lr_req;
    logic [63:0] lr_rdata;

    icl_backing_mem u_bmem (
        .aclk  (aclk),
        .req   (bm_req),
        .rdata (bm_rdata)
    );

    icl_line_ram u_lram (
        .aclk  (aclk),
        .req   (lr_req),
        .rdata (lr_rdata)
    );

    // shared tag lookup, its line chosen by the sequencer step
    logic [LINE_W-1:0]  lk_line;
    logic [SET_W-1:0]   lk_set;
    logic               lk_hit;
    logic [WAY_W-1:0]   lk_way;
    logic [LINE_W-1:0]  q_ln;
    logic [SLOT_W-1:0]  slot_idx;

    assign q_ln     = q_base_reg + LINE_W'(1);
    assign slot_idx = slot_reg[SLOT_W-1:0];

    always_comb begin
        unique case (state_reg)
            ST_SLOT:  lk_line = pf_line_reg[slot_idx];
            ST_QUEUE: lk_line = q_ln;
            default:  lk_line = cur_line_reg;
        endcase
        lk_set = lk_line[SET_W-1:0];
        lk_hit = 1'b0;
        lk_way = '0;
        for (int w = WAY_COUNT - 1; w >= 0; w--) begin
            if (valid_reg[lk_set][w] && tag_reg[lk_set][w] == lk_line[LINE_W-1:SET_W]) begin
                lk_hit = 1'b1;
                lk_way = WAY_W'(w);
            end
        end
    end

    // queue step: duplicate check and first free slot
    logic              q_dup;
    logic              q_free;
    logic [SLOT_W-1:0] q_slot;

    always_comb begin
        q_dup  = d_pend_reg && (d_line_reg == q_ln);
        q_free = 1'b0;
        q_slot = '0;
        for (int i = 0; i < PREFETCH_SLOTS; i++) begin
            if (pf_pend_reg[i] && pf_line_reg[i] == q_ln) begin
                q_dup = 1'b1;
            end
        end
        for (int i = PREFETCH_SLOTS - 1; i >= 0; i--) begin
            if (!pf_pend_reg[i]) begin
                q_free = 1'b1;
                q_slot = SLOT_W'(i);
            end
        end
    end

    // demand step: first pending slot that holds the fetched line
    logic              d_match;
    logic [SLOT_W-1:0] d_slot;

    always_comb begin
        d_match = 1'b0;
        d_slot  = '0;
        for (int i = PREFETCH_SLOTS - 1; i >= 0; i--) begin
            if (pf_pend_reg[i] && pf_line_reg[i] == cur_line_reg) begin
                d_match = 1'b1;
                d_slot  = SLOT_W'(i);
            end
        end
    end

    // fill addressing
    logic [SET_W-1:0] f_set;
    logic [WAY_W-1:0] f_way;
    logic             f_oob;

    assign f_set = fill_line_reg[SET_W-1:0];
    assign f_way = lru_reg[f_set][WAY_COUNT-1];
    // rows beyond the store read as zero
    assign f_oob = (fill_line_reg[LINE_W-1:ROW_W-WORD_W] != '0);

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        lat_next       = cfg_wr_en ? cfg_wr_data : lat_reg;
        tag_next       = tag_reg;
        valid_next     = valid_reg;
        lru_next       = lru_reg;
        pf_pend_next   = pf_pend_reg;
        pf_line_next   = pf_line_reg;
        pf_cd_next     = pf_cd_reg;
        d_pend_next    = d_pend_reg;
        d_line_next    = d_line_reg;
        d_cd_next      = d_cd_reg;
        miss_next      = miss_reg;
        stall_next     = stall_reg;
        cur_line_next  = cur_line_reg;
        cur_word_next  = cur_word_reg;
        cur_flush_next = cur_flush_reg;
        res_word_next  = res_word_reg;
        res_rdy_next   = res_rdy_reg;
        slot_next      = slot_reg;
        q_base_next    = q_base_reg;
        q_left_next    = q_left_reg;
        q_ret_next     = q_ret_reg;
        fill_line_next = fill_line_reg;
        fill_ret_next  = fill_ret_reg;
        fill_cnt_next  = fill_cnt_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_word_next    = m_word_reg;
        m_rdy_next     = m_rdy_reg;
        m_miss_next    = m_miss_reg;
        m_stall_next   = m_stall_reg;
        bm_req         = '0;
        lr_req         = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                // zero sweep of the backing store after reset
                bm_req.we    = 1'b1;
                bm_req.waddr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ROW_W'(MEM_ROWS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_cmd == CMD_LOAD) begin
                        // load request: write one backing word
                        bm_req.we     = 1'b1;
                        bm_req.waddr  = s_mem_index;
                        bm_req.wdata  = s_mem_word;
                        res_word_next = '0;
                        res_rdy_next  = 1'b0;
                        state_next    = ST_RESP;
                    end else begin
                        cur_line_next  = s_pc[63:6];
                        cur_word_next  = s_pc[5:3];
                        cur_flush_next = s_flush;
                        state_next     = ST_LOOK;
                    end
                end
            end
            ST_LOOK: begin
                // hit with no demand miss pending returns the word
                res_word_next = '0;
                res_rdy_next  = 1'b0;
                if (lk_hit && !d_pend_reg) begin
                    lr_req.re        = 1'b1;
                    lr_req.raddr     = {lk_set, lk_way, cur_word_reg};
                    res_rdy_next     = 1'b1;
                    lru_next[lk_set] = make_mru(lru_reg[lk_set], lk_way);
                end
                state_next = ST_WORD;
            end
            ST_WORD: begin
                if (res_rdy_reg) begin
                    res_word_next = lr_rdata;
                end
                if (cur_flush_reg) begin
                    pf_pend_next = '0;
                end
                slot_next  = '0;
                state_next = ST_SLOT;
            end
            ST_SLOT: begin
                // walk the prefetch slots in order against live state
                if (slot_reg == (SLOT_W+1)'(PREFETCH_SLOTS)) begin
                    state_next = ST_DEMAND;
                end else begin
                    slot_next = slot_reg + 1'b1;
                    if (pf_pend_reg[slot_idx]) begin
                        if (pf_cd_reg[slot_idx] > LAT_W'(1)) begin
                            pf_cd_next[slot_idx] = pf_cd_reg[slot_idx] - 1'b1;
                        end else begin
                            pf_cd_next[slot_idx]   = '0;
                            pf_pend_next[slot_idx] = 1'b0;
                            q_base_next = pf_line_reg[slot_idx];
                            q_left_next = 2'd1;
                            q_ret_next  = ST_SLOT;
                            if (lk_hit) begin
                                state_next = ST_QUEUE;
                            end else begin
                                fill_line_next = pf_line_reg[slot_idx];
                                fill_ret_next  = ST_QUEUE;
                                fill_cnt_next  = '0;
                                state_next     = ST_FILL;
                            end
                        end
                    end
                end
            end
            ST_DEMAND: begin
                if (d_pend_reg) begin
                    if (stall_reg != '1) begin
                        stall_next = stall_reg + 1'b1;
                    end
                    if (d_cd_reg > LAT_W'(1)) begin
                        d_cd_next  = d_cd_reg - 1'b1;
                        state_next = ST_RESP;
                    end else begin
                        // demand fill always takes the lru way
                        d_cd_next      = '0;
                        d_pend_next    = 1'b0;
                        q_base_next    = d_line_reg;
                        q_left_next    = 2'd2;
                        q_ret_next     = ST_RESP;
                        fill_line_next = d_line_reg;
                        fill_ret_next  = ST_QUEUE;
                        fill_cnt_next  = '0;
                        state_next     = ST_FILL;
                    end
                end else if (lk_hit) begin
                    q_base_next = cur_line_reg;
                    q_left_next = 2'd2;
                    q_ret_next  = ST_RESP;
                    state_next  = ST_QUEUE;
                end else begin
                    d_pend_next = 1'b1;
                    d_line_next = cur_line_reg;
                    if (miss_reg != '1) begin
                        miss_next = miss_reg + 1'b1;
                    end
                    if (d_match) begin
                        // take over the pending prefetch and its count
                        d_cd_next            = pf_cd_reg[d_slot];
                        pf_pend_next[d_slot] = 1'b0;
                        state_next           = ST_RESP;
                    end else begin
                        d_cd_next   = lat_reg;
                        q_base_next = cur_line_reg;
                        q_left_next = 2'd1;
                        q_ret_next  = ST_RESP;
                        state_next  = ST_QUEUE;
                    end
                end
            end
            ST_QUEUE: begin
                // queue the next line, dropped if cached, pending or no slot
                if (q_left_reg == '0) begin
                    state_next = q_ret_reg;
                end else begin
                    q_base_next = q_ln;
                    q_left_next = q_left_reg - 1'b1;
                    if (!lk_hit && !q_dup && q_free) begin
                        pf_pend_next[q_slot] = 1'b1;
                        pf_line_next[q_slot] = q_ln;
                        pf_cd_next[q_slot]   = lat_reg;
                    end
                end
            end
            ST_FILL: begin
                // stream eight rows, writing each in the cycle after its read
                if (fill_cnt_reg != (WORD_W+1)'(LINE_WORDS)) begin
                    bm_req.re    = 1'b1;
                    bm_req.raddr = {fill_line_reg[ROW_W-WORD_W-1:0],
                                    fill_cnt_reg[WORD_W-1:0]};
                end
                if (fill_cnt_reg != '0) begin
                    lr_req.we    = 1'b1;
                    lr_req.waddr = {f_set, f_way, WORD_W'(fill_cnt_reg - 1'b1)};
                    lr_req.wdata = f_oob ? 64'd0 : bm_rdata;
                end
                if (fill_cnt_reg == (WORD_W+1)'(LINE_WORDS)) begin
                    tag_next[f_set][f_way]   = fill_line_reg[LINE_W-1:SET_W];
                    valid_next[f_set][f_way] = 1'b1;
                    lru_next[f_set]          = make_mru(lru_reg[f_set], f_way);
                    state_next               = fill_ret_reg;
                end else begin
                    fill_cnt_next = fill_cnt_reg + 1'b1;
                end
            end
            ST_RESP: begin
                // hand the result over once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_word_next  = res_word_reg;
                    m_rdy_next   = res_rdy_reg;
                    m_miss_next  = miss_reg;
                    m_stall_next = stall_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            lat_reg     <= LAT_W'(8);
            valid_reg   <= '0;
            for (int s = 0; s < SET_COUNT; s++) begin
                for (int w = 0; w < WAY_COUNT; w++) begin
                    lru_reg[s][w] <= WAY_W'(w);
                end
            end
            pf_pend_reg <= '0;
            for (int i = 0; i < PREFETCH_SLOTS; i++) begin
                pf_cd_reg[i] <= '0;
            end
            d_pend_reg  <= 1'b0;
            d_cd_reg    <= '0;
            miss_reg    <= '0;
            stall_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            lat_reg     <= lat_next;
            valid_reg   <= valid_next;
            lru_reg     <= lru_next;
            pf_pend_reg <= pf_pend_next;
            pf_cd_reg   <= pf_cd_next;
            d_pend_reg  <= d_pend_next;
            d_cd_reg    <= d_cd_next;
            miss_reg    <= miss_next;
            stall_reg   <= stall_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        tag_reg       <= tag_next;
        pf_line_reg   <= pf_line_next;
        d_line_reg    <= d_line_next;
        cur_line_reg  <= cur_line_next;
        cur_word_reg  <= cur_word_next;
        cur_flush_reg <= cur_flush_next;
        res_word_reg  <= res_word_next;
        res_rdy_reg   <= res_rdy_next;
        slot_reg      <= slot_next;
        q_base_reg    <= q_base_next;
        q_left_reg    <= q_left_next;
        q_ret_reg     <= q_ret_next;
        fill_line_reg <= fill_line_next;
        fill_ret_reg  <= fill_ret_next;
        fill_cnt_reg  <= fill_cnt_next;
        m_word_reg    <= m_word_next;
        m_rdy_reg     <= m_rdy_next;
        m_miss_reg    <= m_miss_next;
        m_stall_reg   <= m_stall_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_instr_word  = m_word_reg;
    assign m_ready_res   = m_rdy_reg;
    assign m_miss_total  = m_miss_reg;
    assign m_stall_total = m_stall_reg;
endmodule
`default_nettype wire

/* rtl/core/icl_checker.sv */
// icl_checker: port-level assertions for the instruction cache
// depends on the top level ports only; bound to icache_lru_next_line_prefetch
`default_nettype none
module icl_port_props (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [63:0] m_instr_word,
    input wire logic        m_ready_res,
    input wire logic [31:0] m_miss_total
);
    // a stalled result stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its miss total
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_miss_total))
        else $error("result changed while stalled");

    // a stall result carries no word
    a_stall_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready_res |-> m_instr_word == 64'd0)
        else $error("word on a stall result");

    // one request in flight at a time
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while busy");
endmodule

bind icache_lru_next_line_prefetch icl_port_props u_icl_port_props (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_instr_word (m_instr_word),
    .m_ready_res  (m_ready_res),
    .m_miss_total (m_miss_total)
);
`default_nettype wire
